FILE: rtl/core/dmarg_pkg.sv
// shared types and constants for the distribution marginalizer
// no dependencies; used by dmarg_ctrl, dmarg_datapath and the top level
`default_nettype none

package dmarg_pkg;

    // field widths of one input item and one result item
    localparam int OPCODE_W = 1;
    localparam int SRC_IDX_W = 16;
    localparam int PROB_W = 32;
    localparam int BIN_NUM_W = 10;
    localparam int BIN_VAL_W = 36;

    // packed tdata layout, lowest field first
    localparam int OPCODE_LSB = 0;
    localparam int SRC_IDX_LSB = OPCODE_LSB + OPCODE_W;
    localparam int PROB_LSB = SRC_IDX_LSB + SRC_IDX_W;
    localparam int BIN_NUM_LSB = PROB_LSB + PROB_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // configuration registers
    localparam int SEL_FIELD_W = 4;
    localparam int SEL_FIELDS = 10;
    localparam int BIT_SELECT_W = SEL_FIELD_W * SEL_FIELDS;
    localparam int KEPT_COUNT_W = 4;
    localparam int CFG_DATA_W = BIT_SELECT_W;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_SELECT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEPT_COUNT = 1'b1;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OP_ACCUMULATE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } dmarg_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // take the input item, start the bin read
        logic clear_wr;  // write zero at the clear counter
        logic commit;    // write back the updated bin
        logic out_load;  // move the bin content into the output register
    } dmarg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_read;   // held item is a read and clear
        logic out_free;  // output register can take a result this cycle
        logic clr_last;  // clear counter is at the last bin
    } dmarg_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dmarg_ctrl.sv
// controller for the distribution marginalizer: clear sweep and item sequencing
// depends on dmarg_pkg
`default_nettype none

module dmarg_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire dmarg_pkg::dmarg_sts_t sts,
    output dmarg_pkg::dmarg_cmd_t      cmd
);

    dmarg_pkg::dmarg_state_t state_reg;
    dmarg_pkg::dmarg_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmarg_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            dmarg_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = dmarg_pkg::ST_IDLE;
                end
            end
            dmarg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = dmarg_pkg::ST_UPDATE;
                end
            end
            dmarg_pkg::ST_UPDATE: begin
                // a read waits here until the output register has room
                if (!sts.op_read) begin
                    cmd.commit = 1'b1;
                    state_next = dmarg_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next = dmarg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmarg_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/dmarg_datapath.sv
// datapath for the distribution marginalizer: config registers, index mapping,
// bin memory with saturating read-modify-write, output register; depends on dmarg_pkg
`default_nettype none

module dmarg_datapath #(
    parameter int SRC_BITS = 16,
    parameter int DST_BITS = 10
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire dmarg_pkg::dmarg_cmd_t                  cmd,
    output dmarg_pkg::dmarg_sts_t                       sts,
    input  wire logic [dmarg_pkg::BIN_NUM_LSB+dmarg_pkg::BIN_NUM_W-1:0] s_item,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [dmarg_pkg::CFG_INDEX_W-1:0]      cfg_wr_index,
    input  wire logic [dmarg_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  wire logic                                   m_tready,
    output logic                                        m_tvalid,
    output logic [dmarg_pkg::BIN_VAL_W-1:0]             m_bin_value
);

    localparam int BIN_COUNT = 1 << DST_BITS;
    localparam logic [dmarg_pkg::SRC_IDX_W-1:0] SRC_MASK =
        dmarg_pkg::SRC_IDX_W'((32'(1) << SRC_BITS) - 32'(1));
    localparam logic [dmarg_pkg::KEPT_COUNT_W-1:0] KEEP_MAX =
        dmarg_pkg::KEPT_COUNT_W'(DST_BITS);
    localparam logic [dmarg_pkg::BIN_VAL_W-1:0] BIN_MAX = '1;

    logic [dmarg_pkg::BIT_SELECT_W-1:0] bit_select_reg;
    logic [dmarg_pkg::KEPT_COUNT_W-1:0] kept_count_reg;

    logic [dmarg_pkg::BIN_VAL_W-1:0] bin_mem [BIN_COUNT];
    logic [dmarg_pkg::BIN_VAL_W-1:0] rd_data_reg;
    logic [DST_BITS-1:0]             addr_reg;
    logic                            op_read_reg;
    logic [dmarg_pkg::PROB_W-1:0]    prob_reg;
    logic [DST_BITS-1:0]             clr_cnt_reg;
    logic                            out_valid_reg;
    logic [dmarg_pkg::BIN_VAL_W-1:0] out_data_reg;

    logic [dmarg_pkg::OPCODE_W-1:0]   in_opcode;
    logic [dmarg_pkg::SRC_IDX_W-1:0]  in_src;
    logic [dmarg_pkg::PROB_W-1:0]     in_prob;
    logic [DST_BITS-1:0]              in_bin;
    logic [dmarg_pkg::KEPT_COUNT_W-1:0] keep_eff;
    logic [DST_BITS-1:0]              dst_idx;
    logic [DST_BITS-1:0]              rd_addr;
    logic [dmarg_pkg::BIN_VAL_W:0]    sum;
    logic [dmarg_pkg::BIN_VAL_W-1:0]  upd_value;
    logic                             mem_we;
    logic [DST_BITS-1:0]              wr_addr;
    logic [dmarg_pkg::BIN_VAL_W-1:0]  wr_data;

    // unpack the input item
    assign in_opcode = s_item[dmarg_pkg::OPCODE_LSB +: dmarg_pkg::OPCODE_W];
    assign in_src    = s_item[dmarg_pkg::SRC_IDX_LSB +: dmarg_pkg::SRC_IDX_W] & SRC_MASK;
    assign in_prob   = s_item[dmarg_pkg::PROB_LSB +: dmarg_pkg::PROB_W];
    assign in_bin    = s_item[dmarg_pkg::BIN_NUM_LSB +: DST_BITS];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_select_reg <= '0;
            kept_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                dmarg_pkg::CFG_BIT_SELECT: bit_select_reg <= cfg_wr_data;
                dmarg_pkg::CFG_KEPT_COUNT:
                    kept_count_reg <= cfg_wr_data[dmarg_pkg::KEPT_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // destination index: bit k copies the selected source bit, k below the kept count
    assign keep_eff = (kept_count_reg > KEEP_MAX) ? KEEP_MAX : kept_count_reg;

    always_comb begin
        logic [dmarg_pkg::SEL_FIELD_W-1:0] sel;
        dst_idx = '0;
        for (int k = 0; k < DST_BITS; k++) begin
            sel = bit_select_reg[k*dmarg_pkg::SEL_FIELD_W +: dmarg_pkg::SEL_FIELD_W];
            dst_idx[k] = (dmarg_pkg::KEPT_COUNT_W'(k) < keep_eff) && in_src[sel];
        end
    end

    assign rd_addr = (in_opcode == dmarg_pkg::OP_READ_CLEAR) ? in_bin : dst_idx;

    // held item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg    <= rd_addr;
            op_read_reg <= (in_opcode == dmarg_pkg::OP_READ_CLEAR);
            prob_reg    <= in_prob;
        end
    end

    // clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // saturating update, or zero after a read
    assign sum = {1'b0, rd_data_reg} + (dmarg_pkg::BIN_VAL_W+1)'(prob_reg);
    assign upd_value = op_read_reg ? '0 :
                       (sum[dmarg_pkg::BIN_VAL_W] ? BIN_MAX : sum[dmarg_pkg::BIN_VAL_W-1:0]);

    assign mem_we  = cmd.clear_wr | cmd.commit;
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : addr_reg;
    assign wr_data = cmd.clear_wr ? '0 : upd_value;

    // bin memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= rd_data_reg;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_bin_value = out_data_reg;

    assign sts.op_read  = op_read_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.clr_last = &clr_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/core/distribution_marginalizer.sv
// top level of the distribution marginalizer
// depends on dmarg_pkg, dmarg_ctrl and dmarg_datapath
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_tvalid/s_tready  | s_tdata: opcode, source_index,
//            |           |                    |   prob_value, bin_number
//   m_       | out       | m_tvalid/m_tready  | m_tdata: bin_value
//   cfg_     | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
// an item's bin is read in the idle state and written back in the update
// state through the single write port of the bin memory; items are handled
// one at a time. after reset the block sweeps all 2**DST_BITS bins (1024 at
// the default) to zero with s_tready low; config writes are taken throughout.
// a read item waits in its write-back cycle only while the output register
// holds a result that m_tready has not taken.
`default_nettype none

module distribution_marginalizer #(
    parameter int SRC_BITS = 16,
    parameter int DST_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [0] opcode, [16:1] source_index, [48:17] prob_value, [58:49] bin_number
    input  wire logic [dmarg_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [35:0] bin_value
    output logic [dmarg_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [dmarg_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [dmarg_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    dmarg_pkg::dmarg_cmd_t           cmd;
    dmarg_pkg::dmarg_sts_t           sts;
    logic [dmarg_pkg::BIN_VAL_W-1:0] bin_value;

    // sequencing
    dmarg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    dmarg_datapath #(
        .SRC_BITS (SRC_BITS),
        .DST_BITS (DST_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_item       (s_tdata[dmarg_pkg::BIN_NUM_LSB+dmarg_pkg::BIN_NUM_W-1:0]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_bin_value  (bin_value)
    );

    // pad the result to whole bytes
    assign m_tdata = {{(dmarg_pkg::M_TDATA_W-dmarg_pkg::BIN_VAL_W){1'b0}}, bin_value};

endmodule

`default_nettype wire

FILE: sim/distribution_marginalizer_test.sv
// self-checking testbench for distribution_marginalizer: random accumulate and read items
// against a bin store predictor kept in the testbench; depends on dmarg_pkg and the rtl
`timescale 1ns / 1ps

module distribution_marginalizer_test;

    localparam int BIN_COUNT = 1 << dmarg_pkg::BIN_NUM_W;
    localparam logic [dmarg_pkg::BIN_VAL_W-1:0] BIN_FULL = '1;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 218;
    localparam int HOLD_PHASE = 2;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [dmarg_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [dmarg_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                              cfg_wr_en = 1'b0;
    logic [dmarg_pkg::CFG_INDEX_W-1:0] cfg_wr_index = dmarg_pkg::CFG_BIT_SELECT;
    logic [dmarg_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;

    distribution_marginalizer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // items waiting for the driver, bin contents owed to the result side
    logic [dmarg_pkg::S_TDATA_W-1:0] items_to_send [$];
    logic [dmarg_pkg::BIN_VAL_W-1:0] bin_reads_due [$];

    // predictor state
    logic [dmarg_pkg::BIN_VAL_W-1:0]    bin_model [BIN_COUNT];
    logic [dmarg_pkg::BIT_SELECT_W-1:0] select_model;
    logic [dmarg_pkg::KEPT_COUNT_W-1:0] kept_model;

    // stimulus side copy of the settings, used to aim reads at filled bins
    logic [dmarg_pkg::BIT_SELECT_W-1:0] gen_select = '0;
    logic [dmarg_pkg::KEPT_COUNT_W-1:0] gen_kept = '0;
    logic [dmarg_pkg::SRC_IDX_W-1:0]    recent_sources [$];

    int phase_num = 0;
    int send_idle_pct = 20;
    int take_idle_pct = 20;
    int send_gap = 0;
    int take_gap = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;

    int errors = 0;
    int accumulates_sent = 0;
    int reads_sent = 0;
    int results_ok = 0;
    int saturated_seen = 0;
    int cycle_count = 0;

    // destination bin of a source index under a select and kept count
    function automatic logic [dmarg_pkg::BIN_NUM_W-1:0] bin_of_source(
        input logic [dmarg_pkg::SRC_IDX_W-1:0]    src,
        input logic [dmarg_pkg::BIT_SELECT_W-1:0] sel,
        input logic [dmarg_pkg::KEPT_COUNT_W-1:0] kept
    );
        logic [dmarg_pkg::BIN_NUM_W-1:0] dst;
        int keep;
        int pick;
        dst = '0;
        keep = (kept > dmarg_pkg::BIN_NUM_W) ? dmarg_pkg::BIN_NUM_W : int'(kept);
        for (int k = 0; k < keep; k++) begin
            pick = int'(sel[k*dmarg_pkg::SEL_FIELD_W +: dmarg_pkg::SEL_FIELD_W]);
            // a field naming a bit past the source width gives zero
            if (pick < dmarg_pkg::SRC_IDX_W)
                dst[k] = src[pick];
        end
        return dst;
    endfunction

    task automatic queue_item(
        input logic [dmarg_pkg::OPCODE_W-1:0]  op,
        input logic [dmarg_pkg::SRC_IDX_W-1:0] src,
        input logic [dmarg_pkg::PROB_W-1:0]    prob,
        input logic [dmarg_pkg::BIN_NUM_W-1:0] bin
    );
        logic [dmarg_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[dmarg_pkg::OPCODE_LSB +: dmarg_pkg::OPCODE_W] = op;
        word[dmarg_pkg::SRC_IDX_LSB +: dmarg_pkg::SRC_IDX_W] = src;
        word[dmarg_pkg::PROB_LSB +: dmarg_pkg::PROB_W] = prob;
        word[dmarg_pkg::BIN_NUM_LSB +: dmarg_pkg::BIN_NUM_W] = bin;
        items_to_send.insert(items_to_send.size(), word);
    endtask

    // mostly accumulates, reads aimed at recently filled bins plus random reads
    task automatic queue_random_items(input int count);
        logic [dmarg_pkg::SRC_IDX_W-1:0] src;
        logic [dmarg_pkg::PROB_W-1:0]    prob;
        logic [dmarg_pkg::BIN_NUM_W-1:0] bin;
        int roll;
        for (int i = 0; i < count; i++) begin
            src = dmarg_pkg::SRC_IDX_W'($urandom);
            bin = dmarg_pkg::BIN_NUM_W'($urandom);
            roll = $urandom_range(0, 9);
            prob = (roll == 0) ? '0 : (roll < 3) ? '1 : $urandom;
            if ($urandom_range(0, 99) < 65) begin
                queue_item(dmarg_pkg::OP_ACCUMULATE, src, prob, bin);
                recent_sources.insert(recent_sources.size(), src);
                if (recent_sources.size() > 8)
                    void'(recent_sources.pop_front());
            end else begin
                if (recent_sources.size() > 0 && $urandom_range(0, 9) < 7)
                    bin = bin_of_source(recent_sources[$urandom_range(0,
                        recent_sources.size() - 1)], gen_select, gen_kept);
                queue_item(dmarg_pkg::OP_READ_CLEAR, src, prob, bin);
            end
        end
    endtask

    // both registers, upper write data bits random where the register is narrower
    task automatic write_config(
        input logic [dmarg_pkg::BIT_SELECT_W-1:0] sel,
        input logic [dmarg_pkg::KEPT_COUNT_W-1:0] kept
    );
        logic [dmarg_pkg::CFG_DATA_W-1:0] kept_word;
        kept_word = dmarg_pkg::CFG_DATA_W'({$urandom, $urandom});
        kept_word[dmarg_pkg::KEPT_COUNT_W-1:0] = kept;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= dmarg_pkg::CFG_BIT_SELECT;
        cfg_wr_data <= sel;
        @(posedge aclk);
        cfg_wr_index <= dmarg_pkg::CFG_KEPT_COUNT;
        cfg_wr_data <= kept_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gen_select = sel;
        gen_kept = kept;
        recent_sources.delete();
    endtask

    // wait until every item is taken and every read has come back
    task automatic wait_drained;
        @(negedge aclk);
        while (items_to_send.size() != 0 || s_tvalid || bin_reads_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // input driver with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                send_gap <= $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                s_tdata <= items_to_send.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready: one long hold-off in the hold phase, else short bursts
    always @(posedge aclk) begin
        if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            m_tready <= 1'b0;
        end else if (phase_num == HOLD_PHASE && !long_hold_done && m_tvalid) begin
            long_hold_left <= LONG_HOLD_CYCLES - 1;
            long_hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            m_tready <= 1'b0;
        end else if (take_idle_pct != 0 && $urandom_range(0, 99) < take_idle_pct) begin
            take_gap <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // predictor on accepted items and register writes, checker on results
    always @(posedge aclk) begin
        logic [dmarg_pkg::BIN_NUM_W-1:0] bin;
        logic [dmarg_pkg::BIN_VAL_W:0]   sum;
        logic [dmarg_pkg::BIN_VAL_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < BIN_COUNT; i++)
                bin_model[i] = '0;
            select_model = '0;
            kept_model = '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == dmarg_pkg::CFG_BIT_SELECT)
                    select_model = cfg_wr_data[dmarg_pkg::BIT_SELECT_W-1:0];
                else if (cfg_wr_index == dmarg_pkg::CFG_KEPT_COUNT)
                    kept_model = cfg_wr_data[dmarg_pkg::KEPT_COUNT_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata[dmarg_pkg::OPCODE_LSB +: dmarg_pkg::OPCODE_W]
                        == dmarg_pkg::OP_ACCUMULATE) begin
                    bin = bin_of_source(
                        s_tdata[dmarg_pkg::SRC_IDX_LSB +: dmarg_pkg::SRC_IDX_W],
                        select_model, kept_model);
                    sum = {1'b0, bin_model[bin]}
                        + s_tdata[dmarg_pkg::PROB_LSB +: dmarg_pkg::PROB_W];
                    // saturate at the top of Q4.32
                    bin_model[bin] = (sum > BIN_FULL) ? BIN_FULL
                                                      : sum[dmarg_pkg::BIN_VAL_W-1:0];
                    accumulates_sent++;
                end else begin
                    bin = s_tdata[dmarg_pkg::BIN_NUM_LSB +: dmarg_pkg::BIN_NUM_W];
                    bin_reads_due.insert(bin_reads_due.size(), bin_model[bin]);
                    bin_model[bin] = '0;
                    reads_sent++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (bin_reads_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got bin_value %h",
                             $time, m_tdata[dmarg_pkg::BIN_VAL_W-1:0]);
                    errors++;
                end else begin
                    want = bin_reads_due.pop_front();
                    if (m_tdata[dmarg_pkg::BIN_VAL_W-1:0] !== want) begin
                        $display("%0t: bin_value mismatch, expected %h, got %h",
                                 $time, want, m_tdata[dmarg_pkg::BIN_VAL_W-1:0]);
                        errors++;
                    end else begin
                        results_ok++;
                        if (want == BIN_FULL)
                            saturated_seen++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("distribution_marginalizer_test failed");
            $finish;
        end
    end

    // reset, directed items, then random phases under changing settings
    initial begin
        logic [dmarg_pkg::BIT_SELECT_W-1:0] sel;
        logic [dmarg_pkg::KEPT_COUNT_W-1:0] kept;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings send every source to bin 0
        queue_item(dmarg_pkg::OP_READ_CLEAR, '1, '1, '0);
        queue_item(dmarg_pkg::OP_READ_CLEAR, '0, '0, '1);
        queue_item(dmarg_pkg::OP_ACCUMULATE, '0, '0, '1);
        for (int i = 0; i < 17; i++)
            queue_item(dmarg_pkg::OP_ACCUMULATE, '1, '1, '0);
        // saturated bin, then the same bin after its clear
        queue_item(dmarg_pkg::OP_READ_CLEAR, '0, '0, '0);
        queue_item(dmarg_pkg::OP_READ_CLEAR, '0, '0, '0);
        queue_item(dmarg_pkg::OP_ACCUMULATE, 16'h8000, 32'h1, '1);
        queue_item(dmarg_pkg::OP_READ_CLEAR, '1, '1, '0);
        wait_drained();

        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1: begin sel = 40'h98_7654_3210; kept = 4'd10; end
                2: begin sel = '1;               kept = 4'd15; end
                3: begin sel = '0;               kept = 4'd10; end
                4: begin
                    sel = dmarg_pkg::BIT_SELECT_W'({$urandom, $urandom});
                    kept = 4'd1;
                end
                5: begin
                    sel = dmarg_pkg::BIT_SELECT_W'({$urandom, $urandom});
                    kept = dmarg_pkg::KEPT_COUNT_W'($urandom);
                end
                6: begin sel = 40'hFE_DCBA_9876; kept = 4'd12; end
                default: begin
                    sel = dmarg_pkg::BIT_SELECT_W'({$urandom, $urandom});
                    kept = 4'd3;
                end
            endcase
            write_config(sel, kept);
            @(negedge aclk);
            phase_num = p;
            // a stretch with no idling mid-run, and none in the last phase
            send_idle_pct = (p == 3 || p == PHASES) ? 0 : 20;
            take_idle_pct = (p == 3 || p == PHASES) ? 0 : 20;
            queue_random_items(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("sent %0d accumulate and %0d read items over %0d register settings",
                 accumulates_sent, reads_sent, PHASES + 1);
        $display("%0d bin values matched, %0d of them saturated", results_ok, saturated_seen);
        if (errors == 0)
            $display("distribution_marginalizer_test passed");
        else
            $display("distribution_marginalizer_test failed");
        $finish;
    end

endmodule

FILE: distribution_marginalizer.f
rtl/core/dmarg_pkg.sv
rtl/core/dmarg_ctrl.sv
rtl/core/dmarg_datapath.sv
rtl/core/distribution_marginalizer.sv
sim/distribution_marginalizer_test.sv
